// ===== src/chkim_pkg.sv =====
// Shared types and codes for the chained hash key-to-id map.
// Holds word layouts, operation and status codes, and default sizes.
// No dependencies.
package chkim_pkg;

	localparam int KEY_W = 32;
	localparam int ID_W  = 22;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;

	localparam int BUCKETS_DEF = 251;
	localparam int CELLS_DEF   = 256;

	localparam logic [OP_W-1:0] OP_LINK   = 2'd0;
	localparam logic [OP_W-1:0] OP_UNLINK = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_NOMEM    = 2'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] task_key;
		logic [ID_W-1:0]  proc_id;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [ID_W-1:0] found_id;
	} rsp_t;

endpackage

// ===== src/chained_hash_key_to_id_map.sv =====
// Key-to-id map as a separately chained hash table with a free cell pool.
// One operation (link, unlink, lookup) at a time. After reset the block
// clears its bucket heads and free stack before taking a word.
// An operation that is rejected at once (zero key, empty pool, unused code)
// gets its result without a hash or table read. Any other operation finds
// the bucket index (key mod BUCKETS) by reciprocal multiplication in low,
// high and remainder phases, then issues the head read and checks the head;
// the chain walk reads one cell per cycle from the single read port of the
// cell store. In all cases the result is then loaded into the output
// register, and the next word can be taken once it is there.
// A link visits every cell of its chain to reach the tail. A finished result
// waits in an output register so the next word is taken while it is stalled.
// Depends on chkim_pkg and chkim_walk.
module chained_hash_key_to_id_map #(
	parameter int BUCKETS = chkim_pkg::BUCKETS_DEF,
	parameter int CELLS   = chkim_pkg::CELLS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  chkim_pkg::req_t req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output chkim_pkg::rsp_t rsp_data
);

	logic            walk_ready;
	logic            res_valid;
	logic            res_take;
	logic            accept;
	chkim_pkg::rsp_t res;
	logic            rsp_valid_q;
	chkim_pkg::rsp_t rsp_q;

	assign req_stall = !walk_ready;
	assign accept    = req_valid && walk_ready;
	assign res_take  = res_valid && (!rsp_valid_q || !rsp_stall);

	chkim_walk #(.BUCKETS(BUCKETS), .CELLS(CELLS)) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.req       (req_data),
		.ready     (walk_ready),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// hold the result word until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTH
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !walk_ready)
		else $error("sequencer still idle after taking a word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |-> !(rsp_valid_q && rsp_stall))
		else $error("result overwrote a stalled word");

	a_idle_or_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(walk_ready && res_valid))
		else $error("sequencer idle while holding a result");

	a_id_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status != chkim_pkg::ST_OK) |-> (rsp_data.found_id == '0))
		else $error("failed operation returned a nonzero id");
`endif

endmodule

// ===== src/chkim_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for bucket heads, cell fields and the free stack. No dependencies.
module chkim_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/chkim_hash.sv =====
// Bucket selection: key modulo BUCKETS by reciprocal multiplication in low, high and remainder phases.
// Depends on chkim_pkg for the key width.
module chkim_hash #(
	parameter int BUCKETS = chkim_pkg::BUCKETS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [chkim_pkg::KEY_W-1:0]   key,
	output logic                          done,
	output logic [$clog2(BUCKETS)-1:0]    bucket
);

	localparam int BW = $clog2(BUCKETS);
	localparam int RW = BW + 1;
	localparam int KW = chkim_pkg::KEY_W;

	// floor(2^32 / BUCKETS); the quotient it gives is short by at most one
	localparam logic [63:0] RECIP    = (64'd1 << KW) / 64'(BUCKETS);
	localparam logic [15:0] RECIP_LO = RECIP[15:0];
	localparam logic [15:0] RECIP_HI = RECIP[31:16];

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LO   = 2'd1;
	localparam logic [1:0] PH_HI   = 2'd2;
	localparam logic [1:0] PH_REM  = 2'd3;

	logic [1:0]     phase_q;
	logic           done_q;
	logic [KW-1:0]  key_q;
	logic [KW+15:0] prod_q;
	logic [KW-1:0]  quo_q;
	logic [BW-1:0]  rem_q;
	logic [KW+15:0] prod_cur;
	logic [KW+16:0] quo_sum;
	logic [RW-1:0]  rem_raw;
	logic [RW-1:0]  rem_fix;

	// share one 32x16 multiplier: low half of the reciprocal first, then the high half
	always_comb begin
		prod_cur = {16'b0, key_q} * {{KW{1'b0}}, (phase_q == PH_LO) ? RECIP_LO : RECIP_HI};
		quo_sum  = {1'b0, prod_cur} + {17'b0, prod_q[KW+15:16]};
		// remainder estimate lies below 2 * BUCKETS, so RW bits hold it exactly
		rem_raw  = key_q[RW-1:0] - quo_q[RW-1:0] * RW'(BUCKETS);
		rem_fix  = (rem_raw >= RW'(BUCKETS)) ? rem_raw - RW'(BUCKETS) : rem_raw;
	end

	// phase sequence and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_REM);
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_LO;
					end
				end
				PH_LO: begin
					phase_q <= PH_HI;
				end
				PH_HI: begin
					phase_q <= PH_REM;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// key, partial product, quotient and remainder
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					key_q <= key;
				end
			end
			PH_LO: begin
				prod_q <= prod_cur;
			end
			PH_HI: begin
				quo_q <= quo_sum[KW+15:16];
			end
			default: begin
				rem_q <= rem_fix[BW-1:0];
			end
		endcase
	end

	assign done   = done_q;
	assign bucket = rem_q;

endmodule

// ===== src/chkim_walk.sv =====
// Table sequencer: bucket heads, cell store and free stack in RAMs, chain walk.
// Depends on chkim_pkg, chkim_ram and chkim_hash.
module chkim_walk #(
	parameter int BUCKETS = chkim_pkg::BUCKETS_DEF,
	parameter int CELLS   = chkim_pkg::CELLS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  chkim_pkg::req_t req,
	output logic            ready,
	output logic            res_valid,
	input  logic            res_take,
	output chkim_pkg::rsp_t res
);

	localparam int BW     = $clog2(BUCKETS);
	localparam int IW     = $clog2(CELLS);
	localparam int CW     = $clog2(CELLS + 1);
	localparam int INIT_N = (BUCKETS > CELLS) ? BUCKETS : CELLS;
	localparam int INIT_W = $clog2(INIT_N);
	localparam int KW     = chkim_pkg::KEY_W;
	localparam int DW     = chkim_pkg::ID_W;

	localparam logic [CW-1:0] NIL = CW'(CELLS);

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HASH = 3'd2;
	localparam logic [2:0] S_HEAD = 3'd3;
	localparam logic [2:0] S_WALK = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]          state_q, state_d;
	logic [INIT_W-1:0]   init_q, init_d;
	logic [CW-1:0]       free_cnt_q, free_cnt_d;
	logic [CW-1:0]       free_top;
	logic [chkim_pkg::OP_W-1:0] op_q;
	logic [KW-1:0]       key_q;
	logic [DW-1:0]       id_q;
	logic [BW-1:0]       bucket_q, bucket_d;
	logic [IW-1:0]       new_cell_q, new_cell_d;
	logic [IW-1:0]       cur_q, cur_d;
	logic [CW-1:0]       prev_q, prev_d;
	chkim_pkg::rsp_t     res_q, res_d;

	logic                hash_start;
	logic                hash_done;
	logic [BW-1:0]       hash_bucket;

	logic                head_we, head_re;
	logic [BW-1:0]       head_waddr, head_raddr;
	logic [CW-1:0]       head_wdata, head_rdata;

	logic                cell_we_full, cell_we_next, cell_re;
	logic [IW-1:0]       cell_waddr, cell_raddr;
	logic [CW-1:0]       cell_wnext;
	logic [KW-1:0]       cell_rkey;
	logic [DW-1:0]       cell_rid;
	logic [CW-1:0]       cell_rnext;

	logic                free_we, free_re;
	logic [IW-1:0]       free_waddr, free_raddr, free_wdata, free_rdata;

	logic                hit_key, hit_pair, at_tail;

	chkim_hash #(.BUCKETS(BUCKETS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req.task_key),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	chkim_ram #(.DEPTH(BUCKETS), .WIDTH(CW)) u_head (
		.clk (clk), .wr_en (head_we), .wr_addr (head_waddr), .wr_data (head_wdata),
		.rd_en (head_re), .rd_addr (head_raddr), .rd_data (head_rdata)
	);

	chkim_ram #(.DEPTH(CELLS), .WIDTH(KW)) u_cell_key (
		.clk (clk), .wr_en (cell_we_full), .wr_addr (cell_waddr), .wr_data (key_q),
		.rd_en (cell_re), .rd_addr (cell_raddr), .rd_data (cell_rkey)
	);

	chkim_ram #(.DEPTH(CELLS), .WIDTH(DW)) u_cell_id (
		.clk (clk), .wr_en (cell_we_full), .wr_addr (cell_waddr), .wr_data (id_q),
		.rd_en (cell_re), .rd_addr (cell_raddr), .rd_data (cell_rid)
	);

	chkim_ram #(.DEPTH(CELLS), .WIDTH(CW)) u_cell_next (
		.clk (clk), .wr_en (cell_we_full | cell_we_next), .wr_addr (cell_waddr),
		.wr_data (cell_wnext),
		.rd_en (cell_re), .rd_addr (cell_raddr), .rd_data (cell_rnext)
	);

	chkim_ram #(.DEPTH(CELLS), .WIDTH(IW)) u_free (
		.clk (clk), .wr_en (free_we), .wr_addr (free_waddr), .wr_data (free_wdata),
		.rd_en (free_re), .rd_addr (free_raddr), .rd_data (free_rdata)
	);

	assign free_top = free_cnt_q - CW'(1);
	assign hit_key  = (cell_rkey == key_q);
	assign hit_pair = hit_key && (cell_rid == id_q);
	assign at_tail  = (cell_rnext == NIL);

	// sequence one operation: hash, head read, then one cell per cycle
	always_comb begin
		state_d      = state_q;
		init_d       = init_q;
		free_cnt_d   = free_cnt_q;
		bucket_d     = bucket_q;
		new_cell_d   = new_cell_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		res_d        = res_q;
		hash_start   = 1'b0;
		head_we      = 1'b0;
		head_waddr   = bucket_q;
		head_wdata   = NIL;
		head_re      = 1'b0;
		head_raddr   = hash_bucket;
		cell_we_full = 1'b0;
		cell_we_next = 1'b0;
		cell_waddr   = cur_q;
		cell_wnext   = NIL;
		cell_re      = 1'b0;
		cell_raddr   = cell_rnext[IW-1:0];
		free_we      = 1'b0;
		free_waddr   = free_cnt_q[IW-1:0];
		free_wdata   = cur_q;
		free_re      = 1'b0;
		free_raddr   = free_top[IW-1:0];

		case (state_q)
			S_INIT: begin
				// empty every bucket and stack every cell
				head_we    = ({1'b0, init_q} < (INIT_W+1)'(BUCKETS));
				head_waddr = init_q[BW-1:0];
				free_we    = ({1'b0, init_q} < (INIT_W+1)'(CELLS));
				free_waddr = init_q[IW-1:0];
				free_wdata = init_q[IW-1:0];
				if (init_q == INIT_W'(INIT_N - 1)) begin
					state_d = S_IDLE;
				end else begin
					init_d = init_q + INIT_W'(1);
				end
			end
			S_IDLE: begin
				if (start) begin
					case (req.operation)
						chkim_pkg::OP_LINK: begin
							if (req.task_key == '0 || free_cnt_q == '0) begin
								res_d   = '{status: chkim_pkg::ST_NOMEM, found_id: '0};
								state_d = S_DONE;
							end else begin
								// pop a free cell while the bucket is computed
								free_cnt_d = free_top;
								free_re    = 1'b1;
								hash_start = 1'b1;
								state_d    = S_HASH;
							end
						end
						chkim_pkg::OP_UNLINK, chkim_pkg::OP_LOOKUP: begin
							if (req.task_key == '0) begin
								res_d   = '{status: chkim_pkg::ST_NOTFOUND, found_id: '0};
								state_d = S_DONE;
							end else begin
								hash_start = 1'b1;
								state_d    = S_HASH;
							end
						end
						default: begin
							res_d   = '{status: chkim_pkg::ST_NOTFOUND, found_id: '0};
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_HASH: begin
				if (hash_done) begin
					bucket_d = hash_bucket;
					head_re  = 1'b1;
					if (op_q == chkim_pkg::OP_LINK) begin
						// fill the new cell as a chain end
						cell_we_full = 1'b1;
						cell_waddr   = free_rdata;
						cell_wnext   = NIL;
						new_cell_d   = free_rdata;
					end
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				if (head_rdata == NIL) begin
					if (op_q == chkim_pkg::OP_LINK) begin
						head_we    = 1'b1;
						head_wdata = CW'(new_cell_q);
						res_d      = '{status: chkim_pkg::ST_OK, found_id: '0};
					end else begin
						res_d = '{status: chkim_pkg::ST_NOTFOUND, found_id: '0};
					end
					state_d = S_DONE;
				end else begin
					cur_d      = head_rdata[IW-1:0];
					prev_d     = NIL;
					cell_re    = 1'b1;
					cell_raddr = head_rdata[IW-1:0];
					state_d    = S_WALK;
				end
			end
			S_WALK: begin
				case (op_q)
					chkim_pkg::OP_LINK: begin
						if (at_tail) begin
							// append the new cell behind the tail
							cell_we_next = 1'b1;
							cell_wnext   = CW'(new_cell_q);
							res_d        = '{status: chkim_pkg::ST_OK, found_id: '0};
							state_d      = S_DONE;
						end else begin
							cur_d   = cell_rnext[IW-1:0];
							cell_re = 1'b1;
						end
					end
					chkim_pkg::OP_LOOKUP: begin
						if (hit_key) begin
							res_d   = '{status: chkim_pkg::ST_OK, found_id: cell_rid};
							state_d = S_DONE;
						end else if (at_tail) begin
							res_d   = '{status: chkim_pkg::ST_NOTFOUND, found_id: '0};
							state_d = S_DONE;
						end else begin
							cur_d   = cell_rnext[IW-1:0];
							cell_re = 1'b1;
						end
					end
					default: begin
						if (hit_pair) begin
							// bypass the cell and push it back on the free stack
							if (prev_q == NIL) begin
								head_we    = 1'b1;
								head_wdata = cell_rnext;
							end else begin
								cell_we_next = 1'b1;
								cell_waddr   = prev_q[IW-1:0];
								cell_wnext   = cell_rnext;
							end
							free_we    = 1'b1;
							free_cnt_d = free_cnt_q + CW'(1);
							res_d      = '{status: chkim_pkg::ST_OK, found_id: '0};
							state_d    = S_DONE;
						end else if (at_tail) begin
							res_d   = '{status: chkim_pkg::ST_NOTFOUND, found_id: '0};
							state_d = S_DONE;
						end else begin
							prev_d  = CW'(cur_q);
							cur_d   = cell_rnext[IW-1:0];
							cell_re = 1'b1;
						end
					end
				endcase
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			init_q     <= '0;
			free_cnt_q <= CW'(CELLS);
		end else begin
			state_q    <= state_d;
			init_q     <= init_d;
			free_cnt_q <= free_cnt_d;
		end
	end

	// operation payload and walk pointers
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			op_q  <= req.operation;
			key_q <= req.task_key;
			id_q  <= req.proc_id;
		end
		bucket_q   <= bucket_d;
		new_cell_q <= new_cell_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		res_q      <= res_d;
	end

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule
